>>> design/fbv_pkg.sv
package fbv_pkg;

    localparam int PLANE_COUNT         = 6;
    localparam int AXIS_COUNT          = 3;
    localparam int COMP_COUNT          = 4;
    localparam int COORD_W             = 32;
    localparam int COMP_W              = COORD_W + 1;
    localparam int PROD_W              = COMP_W + COORD_W;
    localparam int SUM_W               = PROD_W + 1;
    localparam int TOTAL_W             = SUM_W + 1;
    localparam int DIST_SHIFT          = 16;
    localparam int COL_W               = 2;
    localparam int S_FIELDS_W          = COL_W + 10 * COORD_W;
    localparam int S_TDATA_W           = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W           = 8;
    localparam int DEFAULT_QUEUE_DEPTH = 4;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEST = 1'b1;

    typedef struct packed {
        logic                               is_box;
        logic [COL_W-1:0]                   column;
        logic [PLANE_COUNT-1:0][COMP_W-1:0] val;
    } entry_t;

endpackage

>>> design/fbv_front.sv
module fbv_front
(
    input  logic [fbv_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    output fbv_pkg::entry_t               entry
);

    localparam int CW = fbv_pkg::COORD_W;
    localparam int KW = fbv_pkg::COMP_W;
    localparam int OW = fbv_pkg::COL_W;

    logic signed [CW-1:0] row [4];
    logic signed [CW-1:0] box [6];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            row[i] = s_tdata[OW + i*CW +: CW];
        end
        for (int i = 0; i < 6; i++)
        begin
            box[i] = s_tdata[OW + (4 + i)*CW +: CW];
        end
        entry.is_box = (s_tuser == fbv_pkg::CMD_TEST);
        entry.column = s_tdata[OW-1:0];
        for (int p = 0; p < fbv_pkg::PLANE_COUNT; p++)
        begin
            if (entry.is_box)
            begin
                entry.val[p] = KW'(box[p]);
            end
            else if (p % 2 == 1)
            begin
                entry.val[p] = KW'(row[3]) - KW'(row[p/2]);
            end
            else
            begin
                entry.val[p] = KW'(row[3]) + KW'(row[p/2]);
            end
        end
    end

endmodule

>>> design/fbv_queue.sv
module fbv_queue
#(
    parameter int DEPTH = fbv_pkg::DEFAULT_QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  fbv_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output fbv_pkg::entry_t head_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    fbv_pkg::entry_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] tail_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign not_empty  = (count_reg != '0);
    assign head_entry = slot_reg[head_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                tail_reg <= (tail_reg == LAST) ? '0 : tail_reg + 1'b1;
            end
            if (pop)
            begin
                head_reg <= (head_reg == LAST) ? '0 : head_reg + 1'b1;
            end
        end
    end

endmodule

>>> design/fbv_back.sv
module fbv_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  fbv_pkg::entry_t               q_entry,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fbv_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tuser
);

    localparam int NP = fbv_pkg::PLANE_COUNT;
    localparam int NA = fbv_pkg::AXIS_COUNT;
    localparam int CW = fbv_pkg::COORD_W;
    localparam int KW = fbv_pkg::COMP_W;
    localparam int PW = fbv_pkg::PROD_W;
    localparam int SW = fbv_pkg::SUM_W;
    localparam int TW = fbv_pkg::TOTAL_W;
    localparam int SH = fbv_pkg::DIST_SHIFT;

    logic [NP-1:0][fbv_pkg::COMP_COUNT-1:0][KW-1:0] plane_reg;

    logic                      advance;
    logic                      v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic                      b1_reg, b2_reg, b3_reg, b4_reg, out_box_reg;
    logic                      out_visible_reg;
    logic [NP-1:0][NA-1:0][KW-1:0] n1_reg;
    logic [NP-1:0][NA-1:0][CW-1:0] q1_reg;
    logic [NP-1:0][KW-1:0]         d1_reg;
    logic [NP-1:0][NA-1:0][PW-1:0] pr2_reg;
    logic [NP-1:0][KW-1:0]         d2_reg;
    logic [NP-1:0][SW-1:0]         s3_reg;
    logic [NP-1:0][SW-1:0]         t3_reg;
    logic [NP-1:0]                 neg4_reg;
    logic [TW-1:0]                 total [NP];

    assign advance  = !out_valid_reg || m_tready;
    assign q_pop    = advance && q_valid;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_box_reg;
    assign m_tdata  = {{(fbv_pkg::M_TDATA_W-1){1'b0}}, out_visible_reg};

    always_comb
    begin
        for (int p = 0; p < NP; p++)
        begin
            total[p] = {s3_reg[p][SW-1], s3_reg[p]} + {t3_reg[p][SW-1], t3_reg[p]};
        end
    end

    // apply loads in queue order so later tests see them
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= '0;
        end
        else if (q_pop && !q_entry.is_box)
        begin
            for (int p = 0; p < NP; p++)
            begin
                plane_reg[p][q_entry.column] <= q_entry.val[p];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            for (int p = 0; p < NP; p++)
            begin
                d1_reg[p] <= plane_reg[p][NA];
                for (int a = 0; a < NA; a++)
                begin
                    n1_reg[p][a] <= plane_reg[p][a];
                    q1_reg[p][a] <= plane_reg[p][a][KW-1] ? q_entry.val[a][CW-1:0]
                                                           : q_entry.val[NA+a][CW-1:0];
                end
            end
        end
        if (advance)
        begin
            for (int p = 0; p < NP; p++)
            begin
                d2_reg[p] <= d1_reg[p];
                for (int a = 0; a < NA; a++)
                begin
                    pr2_reg[p][a] <= PW'($signed(n1_reg[p][a]) * $signed(q1_reg[p][a]));
                end
                s3_reg[p] <= {pr2_reg[p][0][PW-1], pr2_reg[p][0]}
                           + {pr2_reg[p][1][PW-1], pr2_reg[p][1]};
                t3_reg[p] <= {pr2_reg[p][2][PW-1], pr2_reg[p][2]}
                           + {{(SW-KW-SH){d2_reg[p][KW-1]}}, d2_reg[p], {SH{1'b0}}};
                neg4_reg[p] <= total[p][TW-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            v3_reg          <= 1'b0;
            v4_reg          <= 1'b0;
            out_valid_reg   <= 1'b0;
            b1_reg          <= 1'b0;
            b2_reg          <= 1'b0;
            b3_reg          <= 1'b0;
            b4_reg          <= 1'b0;
            out_box_reg     <= 1'b0;
            out_visible_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg          <= q_valid;
            v2_reg          <= v1_reg;
            v3_reg          <= v2_reg;
            v4_reg          <= v3_reg;
            out_valid_reg   <= v4_reg;
            b1_reg          <= q_entry.is_box;
            b2_reg          <= b1_reg;
            b3_reg          <= b2_reg;
            b4_reg          <= b3_reg;
            out_box_reg     <= b4_reg;
            out_visible_reg <= b4_reg && !(|neg4_reg);
        end
    end

endmodule

>>> design/frustum_box_visibility.sv
// Path: an accepted input word is queued, then moves through the back-end pipeline
// registers; all 18 normal-by-corner multipliers run in parallel.
// Throughput: one word per cycle unless the output stalls.
// Reset: clears all plane components to zero and empties the queue and the pipeline.
module frustum_box_visibility
#(
    parameter int QUEUE_DEPTH = fbv_pkg::DEFAULT_QUEUE_DEPTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // column_index, col_row0..col_row3, box_min_x/y/z, box_max_x/y/z, zero pad
    input  logic [fbv_pkg::S_TDATA_W-1:0] s_tdata,
    // command
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // visible, zero pad
    output logic [fbv_pkg::M_TDATA_W-1:0] m_tdata,
    // is_box_answer
    output logic                          m_tuser
);

    fbv_pkg::entry_t in_entry;
    fbv_pkg::entry_t head_entry;
    logic            q_full;
    logic            q_not_empty;
    logic            q_pop;

    assign s_tready = !q_full;

    fbv_front u_front
    (
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .entry   (in_entry)
    );

    fbv_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s_tvalid && s_tready),
        .push_entry (in_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head_entry (head_entry)
    );

    fbv_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_not_empty),
        .q_entry  (head_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
